@@ design/cdq_pkg.sv @@
package cdq_pkg;

    // Store geometry and field widths
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_REAR  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_REAR   = 2'd3
    } t_req_kind;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_FULL       = 2'd1,
        ST_EMPTY      = 2'd2,
        ST_UNUSED     = 2'd3
    } t_status;

    typedef struct packed {
        t_req_kind                     req_type;
        logic signed [DATA_WIDTH-1:0]  push_value;
    } t_in_word;

    typedef struct packed {
        t_status                       status;
        logic signed [DATA_WIDTH-1:0]  front_value;
        logic signed [DATA_WIDTH-1:0]  rear_value;
        logic [CNT_W-1:0]              item_count;
        logic                          is_empty;
        logic                          is_full;
    } t_out_word;

    // Control bundle from the pointer logic to the slot store
    typedef struct packed {
        logic                   we;
        logic [IDX_W-1:0]       waddr;
        logic [DATA_WIDTH-1:0]  wdata;
        logic                   re;
        logic [IDX_W-1:0]       head_addr;
        logic [IDX_W-1:0]       tail_addr;
    } t_store_ctl;

endpackage

@@ design/circular_deque.sv @@
// Double-ended queue in a circular register-file store of 16 slots, of which
// the capacity register selects how many are in use (0 acts as 1, anything
// above 16 as 16); writing the capacity empties the deque. Each request word
// is a push or pop at either end and gives one result word with a status,
// the front and rear values (all ones when empty), the count and the
// empty/full flags. One request is taken every clock cycle while o_stall
// is low: the pointer update, the slot write and both end reads happen
// in the cycle of acceptance, against a store with one write port and two
// registered read ports. A result passes through the result register and
// then the output register; these two let one further request in while a
// result is held by a stalled receiver.
module circular_deque (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  cdq_pkg::t_in_word            i_data,
    output logic                         o_valid,
    input  logic                         i_stall,
    output cdq_pkg::t_out_word           o_data,
    input  logic                         i_cfg_we,
    input  logic [cdq_pkg::CNT_W-1:0]    i_cfg_data
);
    import cdq_pkg::*;

    logic [CNT_W-1:0]      r_cap;
    logic [IDX_W-1:0]      r_head;
    logic [IDX_W-1:0]      r_tail;
    logic [CNT_W-1:0]      r_count;

    logic                  r_res_valid;
    t_status               r_res_status;
    logic [CNT_W-1:0]      r_res_count;
    logic                  r_res_full;

    logic                  r_out_valid;
    t_out_word             r_out;

    logic [IDX_W-1:0]      n_head;
    logic [IDX_W-1:0]      n_tail;
    logic [CNT_W-1:0]      n_count;
    t_status               n_status;
    logic [CNT_W-1:0]      n_cap;

    logic                  in_acc;
    logic                  move;
    logic [IDX_W-1:0]      last;
    logic                  is_pop;
    t_store_ctl            store_ctl;
    logic [DATA_WIDTH-1:0] head_data;
    logic [DATA_WIDTH-1:0] tail_data;

    // Handshake
    assign move    = r_res_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_res_valid && !move;
    assign in_acc  = i_valid && !o_stall;
    assign last    = IDX_W'(r_cap - CNT_W'(1));
    assign is_pop  = i_data.req_type[1];

    // Effective capacity on a configuration write
    always_comb begin
        if (i_cfg_data == '0) begin
            n_cap = CNT_W'(1);
        end else if (i_cfg_data > CNT_W'(DEPTH)) begin
            n_cap = CNT_W'(DEPTH);
        end else begin
            n_cap = i_cfg_data;
        end
    end

    // Pointer update and slot write for one request
    always_comb begin
        n_head          = r_head;
        n_tail          = r_tail;
        n_count         = r_count;
        n_status        = ST_DONE;
        store_ctl.we    = 1'b0;
        store_ctl.waddr = r_head;
        store_ctl.wdata = i_data.push_value;
        unique case (i_data.req_type)
            REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
                if (r_count >= r_cap) begin
                    n_status = ST_FULL;
                end else if (r_count == '0) begin
                    n_head          = '0;
                    n_tail          = '0;
                    n_count         = CNT_W'(1);
                    store_ctl.we    = in_acc;
                    store_ctl.waddr = '0;
                end else if (i_data.req_type == REQ_PUSH_FRONT) begin
                    n_head          = (r_head == '0) ? last : r_head - IDX_W'(1);
                    n_count         = r_count + CNT_W'(1);
                    store_ctl.we    = in_acc;
                    store_ctl.waddr = n_head;
                end else begin
                    n_tail          = (r_tail >= last) ? '0 : r_tail + IDX_W'(1);
                    n_count         = r_count + CNT_W'(1);
                    store_ctl.we    = in_acc;
                    store_ctl.waddr = n_tail;
                end
            end
            REQ_POP_FRONT, REQ_POP_REAR: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (i_data.req_type == REQ_POP_FRONT) begin
                    n_head  = (r_head >= last) ? '0 : r_head + IDX_W'(1);
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_tail  = (r_tail == '0) ? last : r_tail - IDX_W'(1);
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
        store_ctl.re        = in_acc;
        store_ctl.head_addr = n_head;
        store_ctl.tail_addr = n_tail;
    end

    cdq_store u_store (
        .i_clk       (i_clk),
        .i_ctl       (store_ctl),
        .o_head_data (head_data),
        .o_tail_data (tail_data)
    );

    // Deque state; a capacity write empties it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RESET;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_cap   <= n_cap;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (in_acc) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Result register, alongside the store read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (in_acc) begin
            r_res_valid <= 1'b1;
        end else if (move) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res_status <= n_status;
            r_res_count  <= n_count;
            r_res_full   <= (n_count == r_cap);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out.status      <= r_res_status;
            r_out.front_value <= (r_res_count == '0) ? '1 : head_data;
            r_out.rear_value  <= (r_res_count == '0) ? '1 : tail_data;
            r_out.item_count  <= r_res_count;
            r_out.is_empty    <= (r_res_count == '0);
            r_out.is_full     <= r_res_full;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Checks
    a_count_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap)
        else $error("stored count above capacity");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_cfg_we && is_pop && (n_status == ST_DONE))
        |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("accepted pop did not lower the count");

    a_no_stall_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_res_valid |-> !o_stall)
        else $error("input stalled with an empty result register");

    a_res_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !r_out_valid) |=> r_out_valid)
        else $error("result word not moved to a free output register");

endmodule

@@ design/cdq_store.sv @@
module cdq_store (
    input  logic                             i_clk,
    input  cdq_pkg::t_store_ctl              i_ctl,
    output logic [cdq_pkg::DATA_WIDTH-1:0]   o_head_data,
    output logic [cdq_pkg::DATA_WIDTH-1:0]   o_tail_data
);
    import cdq_pkg::*;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_head_data;
    logic [DATA_WIDTH-1:0] r_tail_data;

    // One write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_ctl.wdata;
        end
    end

    // Two registered read ports; a same-cycle write is forwarded
    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            if (i_ctl.we && (i_ctl.waddr == i_ctl.head_addr)) begin
                r_head_data <= i_ctl.wdata;
            end else begin
                r_head_data <= r_mem[i_ctl.head_addr];
            end
            if (i_ctl.we && (i_ctl.waddr == i_ctl.tail_addr)) begin
                r_tail_data <= i_ctl.wdata;
            end else begin
                r_tail_data <= r_mem[i_ctl.tail_addr];
            end
        end
    end

    assign o_head_data = r_head_data;
    assign o_tail_data = r_tail_data;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;

    import cdq_pkg::*;

    localparam int CYCLE_LIMIT = 60000;
    localparam int N_PHASES    = 8;
    localparam int PHASE_WORDS = 50;

    typedef enum bit {STEP_REQ, STEP_CFG} t_step_kind;

    typedef struct {
        t_step_kind                    kind;
        t_req_kind                     req;
        logic signed [DATA_WIDTH-1:0]  value;
        logic [CNT_W-1:0]              cap;
        bit                            typed;
        t_out_word                     want;
    } t_dir_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    t_in_word          i_data;
    logic              o_valid;
    logic              i_stall;
    t_out_word         o_data;
    logic              i_cfg_we;
    logic [CNT_W-1:0]  i_cfg_data;

    circular_deque i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the deque
    logic signed [DATA_WIDTH-1:0] deque_slots [DEPTH];
    int                           deque_head;
    int                           deque_tail;
    int                           deque_fill;
    logic [CNT_W-1:0]             deque_cap;

    t_out_word  pending_results [$];
    t_dir_row   dir_rows [$];
    bit         row_typed;
    t_out_word  row_want;
    bit         steady_run;
    int         mismatch_count;
    int         cycle_count;
    int         n_requests;
    int         n_full_refused;
    int         n_empty_refused;
    int         n_cap_writes;

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int live_cap();
        if (deque_cap == 0)
            return 1;
        if (int'(deque_cap) > DEPTH)
            return DEPTH;
        return int'(deque_cap);
    endfunction

    function automatic void set_capacity(logic [CNT_W-1:0] c);
        deque_cap  = c;
        deque_head = 0;
        deque_tail = 0;
        deque_fill = 0;
    endfunction

    // Apply one request word to the shadow deque, return the result word
    function automatic t_out_word deque_apply(t_in_word w);
        t_out_word r;
        int        cap;
        cap = live_cap();
        r.status = ST_DONE;
        case (w.req_type)
            REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
                if (deque_fill >= cap) begin
                    r.status = ST_FULL;
                end else if (deque_fill == 0) begin
                    // first word lands in slot 0 with both ends on it
                    deque_head     = 0;
                    deque_tail     = 0;
                    deque_slots[0] = w.push_value;
                    deque_fill     = 1;
                end else if (w.req_type == REQ_PUSH_FRONT) begin
                    deque_head = (deque_head == 0) ? cap - 1 : deque_head - 1;
                    deque_slots[deque_head] = w.push_value;
                    deque_fill++;
                end else begin
                    deque_tail = (deque_tail >= cap - 1) ? 0 : deque_tail + 1;
                    deque_slots[deque_tail] = w.push_value;
                    deque_fill++;
                end
            end
            default: begin
                if (deque_fill == 0) begin
                    r.status = ST_EMPTY;
                end else if (w.req_type == REQ_POP_FRONT) begin
                    deque_head = (deque_head >= cap - 1) ? 0 : deque_head + 1;
                    deque_fill--;
                end else begin
                    deque_tail = (deque_tail == 0) ? cap - 1 : deque_tail - 1;
                    deque_fill--;
                end
            end
        endcase
        if (deque_fill == 0) begin
            r.front_value = '1;
            r.rear_value  = '1;
        end else begin
            r.front_value = deque_slots[deque_head];
            r.rear_value  = deque_slots[deque_tail];
        end
        r.item_count = CNT_W'(deque_fill);
        r.is_empty   = (deque_fill == 0);
        r.is_full    = (deque_fill == cap);
        return r;
    endfunction

    task automatic flag_mismatch(string field, logic [DATA_WIDTH-1:0] got,
                                 logic [DATA_WIDTH-1:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    task automatic check_word(t_out_word got, t_out_word want);
        if (got.status != want.status)
            flag_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.front_value != want.front_value)
            flag_mismatch("front_value", got.front_value, want.front_value);
        if (got.rear_value != want.rear_value)
            flag_mismatch("rear_value", got.rear_value, want.rear_value);
        if (got.item_count != want.item_count)
            flag_mismatch("item_count", 32'(got.item_count), 32'(want.item_count));
        if (got.is_empty != want.is_empty)
            flag_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
        if (got.is_full != want.is_full)
            flag_mismatch("is_full", 32'(got.is_full), 32'(want.is_full));
    endtask

    // Watch both channels and the config port at each rising edge
    always @(posedge i_clk) begin : watch
        t_out_word predicted;
        if (i_rst_n) begin
            if (i_cfg_we)
                set_capacity(i_cfg_data);
            if (i_valid && !o_stall) begin
                predicted = deque_apply(i_data);
                pending_results.push_back(row_typed ? row_want : predicted);
                n_requests++;
                if (predicted.status == ST_FULL)
                    n_full_refused++;
                if (predicted.status == ST_EMPTY)
                    n_empty_refused++;
            end
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0)
                    flag_mismatch("unexpected result word", o_data.front_value, '0);
                else
                    check_word(o_data, pending_results.pop_front());
            end
        end
    end

    // Receiver stalls about a quarter of the time
    always @(negedge i_clk)
        i_stall <= steady_run ? 1'b0 : ($urandom_range(0, 99) < 25);

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("** circular_deque: FAILED **");
            $finish;
        end
    end

    // Present one request word and hold it until taken
    task automatic send_req(t_req_kind k, logic signed [DATA_WIDTH-1:0] v,
                            bit typed = 1'b0, t_out_word want = '0);
        @(negedge i_clk);
        row_typed = typed;
        row_want  = want;
        while (!steady_run && $urandom_range(0, 99) < 25) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_data.req_type   <= k;
        i_data.push_value <= v;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    // Stop sending and wait for every outstanding result; returns at a falling edge
    task automatic wait_drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_capacity(logic [CNT_W-1:0] c);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= c;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        n_cap_writes++;
    endtask

    function automatic t_dir_row req_row(t_req_kind k, logic signed [DATA_WIDTH-1:0] v);
        t_dir_row r;
        r.kind  = STEP_REQ;
        r.req   = k;
        r.value = v;
        r.cap   = '0;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic t_dir_row req_row_exp(t_req_kind k, logic signed [DATA_WIDTH-1:0] v,
                                             t_status st, logic [DATA_WIDTH-1:0] front,
                                             logic [DATA_WIDTH-1:0] rear, int cnt, bit full);
        t_dir_row r;
        r                  = req_row(k, v);
        r.typed            = 1'b1;
        r.want.status      = st;
        r.want.front_value = front;
        r.want.rear_value  = rear;
        r.want.item_count  = CNT_W'(cnt);
        r.want.is_empty    = (cnt == 0);
        r.want.is_full     = full;
        return r;
    endfunction

    function automatic t_dir_row cap_row(int c);
        t_dir_row r;
        r      = req_row(REQ_PUSH_FRONT, '0);
        r.kind = STEP_CFG;
        r.cap  = CNT_W'(c);
        return r;
    endfunction

    initial begin : stimulus
        int               phase_caps [N_PHASES];
        t_req_kind        k;
        logic signed [DATA_WIDTH-1:0] v;
        bit               push;
        int               push_pct;

        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_data     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        steady_run = 1'b0;
        row_typed  = 1'b0;
        row_want   = '0;
        foreach (deque_slots[j])
            deque_slots[j] = '0;
        set_capacity(CAP_RESET);

        // Directed table: reset state, value extremes, refusals, odd capacities, wrap
        dir_rows.push_back(req_row_exp(REQ_POP_FRONT, 0, ST_EMPTY, '1, '1, 0, 0));
        dir_rows.push_back(req_row_exp(REQ_POP_REAR, -1, ST_EMPTY, '1, '1, 0, 0));
        dir_rows.push_back(req_row_exp(REQ_PUSH_FRONT, 32'h7fffffff, ST_DONE,
                                       32'h7fffffff, 32'h7fffffff, 1, 0));
        dir_rows.push_back(req_row_exp(REQ_PUSH_REAR, 32'h80000000, ST_DONE,
                                       32'h7fffffff, 32'h80000000, 2, 0));
        dir_rows.push_back(req_row_exp(REQ_PUSH_FRONT, 32'hffffffff, ST_DONE,
                                       32'hffffffff, 32'h80000000, 3, 0));
        dir_rows.push_back(req_row_exp(REQ_PUSH_REAR, 32'h0, ST_DONE,
                                       32'hffffffff, 32'h0, 4, 0));
        dir_rows.push_back(req_row(REQ_POP_FRONT, 32'h0));
        dir_rows.push_back(req_row(REQ_POP_REAR, 32'hffffffff));
        dir_rows.push_back(req_row(REQ_POP_REAR, 32'h0));
        dir_rows.push_back(req_row_exp(REQ_POP_FRONT, 0, ST_DONE, '1, '1, 0, 0));
        dir_rows.push_back(cap_row(1));
        dir_rows.push_back(req_row_exp(REQ_PUSH_REAR, 32'h5a5a5a5a, ST_DONE,
                                       32'h5a5a5a5a, 32'h5a5a5a5a, 1, 1));
        dir_rows.push_back(req_row_exp(REQ_PUSH_FRONT, 32'ha5a5a5a5, ST_FULL,
                                       32'h5a5a5a5a, 32'h5a5a5a5a, 1, 1));
        dir_rows.push_back(req_row_exp(REQ_PUSH_REAR, 32'ha5a5a5a5, ST_FULL,
                                       32'h5a5a5a5a, 32'h5a5a5a5a, 1, 1));
        dir_rows.push_back(req_row_exp(REQ_POP_FRONT, 0, ST_DONE, '1, '1, 0, 0));
        // zero capacity behaves as one slot
        dir_rows.push_back(cap_row(0));
        dir_rows.push_back(req_row_exp(REQ_PUSH_FRONT, 32'h12345678, ST_DONE,
                                       32'h12345678, 32'h12345678, 1, 1));
        dir_rows.push_back(req_row_exp(REQ_PUSH_REAR, 32'h0, ST_FULL,
                                       32'h12345678, 32'h12345678, 1, 1));
        // oversize capacity clamps to the store depth, and the write empties the deque
        dir_rows.push_back(cap_row(31));
        dir_rows.push_back(req_row_exp(REQ_POP_REAR, 0, ST_EMPTY, '1, '1, 0, 0));
        // two slots: both pointers wrap
        dir_rows.push_back(cap_row(2));
        dir_rows.push_back(req_row(REQ_PUSH_FRONT, 32'd1));
        dir_rows.push_back(req_row(REQ_PUSH_FRONT, 32'd2));
        dir_rows.push_back(req_row(REQ_PUSH_REAR, 32'd3));
        dir_rows.push_back(req_row(REQ_POP_REAR, 32'd0));
        dir_rows.push_back(req_row(REQ_PUSH_REAR, 32'd4));
        dir_rows.push_back(req_row(REQ_POP_FRONT, 32'd0));

        // Synchronous reset
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[n]) begin
            if (dir_rows[n].kind == STEP_CFG) begin
                wait_drain();
                write_capacity(dir_rows[n].cap);
            end else begin
                send_req(dir_rows[n].req, dir_rows[n].value,
                         dir_rows[n].typed, dir_rows[n].want);
            end
        end

        // Random phases: fill towards full, then drain towards empty
        phase_caps = '{16, 1, 0, 31, 3, 16, $urandom_range(0, 31), 7};
        for (int p = 0; p < N_PHASES; p++) begin
            wait_drain();
            write_capacity(CNT_W'(phase_caps[p]));
            steady_run = (p == 3);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // hold off once until the pipeline is empty
                if (p == 5 && n == PHASE_WORDS / 2)
                    wait_drain();
                push_pct = (n < PHASE_WORDS / 2) ? 85 : 15;
                push     = ($urandom_range(0, 99) < push_pct);
                if (push)
                    k = $urandom_range(0, 1) ? REQ_PUSH_REAR : REQ_PUSH_FRONT;
                else
                    k = $urandom_range(0, 1) ? REQ_POP_REAR : REQ_POP_FRONT;
                case ($urandom_range(0, 15))
                    0:       v = 32'h7fffffff;
                    1:       v = 32'h80000000;
                    2:       v = '1;
                    3:       v = '0;
                    default: v = $urandom;
                endcase
                send_req(k, v);
            end
        end
        steady_run = 1'b0;

        wait_drain();
        repeat (4) @(posedge i_clk);

        $display("Run covered %0d requests over %0d capacity writes,",
                 n_requests, n_cap_writes);
        $display("including %0d pushes refused as full and %0d pops refused as empty.",
                 n_full_refused, n_empty_refused);
        if (mismatch_count == 0) begin
            $display("** circular_deque: PASSED **");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("** circular_deque: FAILED **");
        end
        $finish;
    end

endmodule
